// ----- design/assert_macros.svh -----
// Assertion macros shared by the frame encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EAFE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame encoder check failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EAFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame encoder check failed: next-cycle implication");

`endif

// ----- design/eafe_pkg.sv -----
// Package with the types, constants and byte helpers of the frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package eafe_pkg;

   // Longest body a begin beat may announce.
   localparam int unsigned MAX_BODY = 255;

   // Wire bytes and escape handling.
   localparam logic [7:0] DELIM     = 8'h7E;
   localparam logic [7:0] ESC       = 8'h7D;
   localparam logic [7:0] XON       = 8'h11;
   localparam logic [7:0] XOFF      = 8'h13;
   localparam logic [7:0] ESC_XOR   = 8'h20;
   localparam logic [7:0] CK_BASE   = 8'hFF;
   localparam logic [7:0] ADDR_HI   = 8'hFF;
   localparam logic [7:0] ADDR_LO   = 8'hFE;
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // Input beat kinds.
   localparam logic [1:0] KIND_BEGIN_TX = 2'd0;
   localparam logic [1:0] KIND_BEGIN_AT = 2'd1;
   localparam logic [1:0] KIND_BODY     = 2'd2;

   // Configuration register indexes and reset values.
   localparam int unsigned CSR_IDX_W   = 1;
   localparam logic [CSR_IDX_W-1:0] REG_TX_TYPE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_AT_TYPE = 1'b1;
   localparam logic [7:0] TX_TYPE_RST = 8'h10;
   localparam logic [7:0] AT_TYPE_RST = 8'h08;

   // Frame bytes ahead of the body, counted in the length field.
   localparam logic [8:0] TX_HDR_LEN = 9'd12;
   localparam logic [8:0] AT_HDR_LEN = 9'd4;

   // Position of the final logical byte of each job (checksum included or not).
   localparam logic [3:0] TX_LAST_CK   = 4'd15;
   localparam logic [3:0] TX_LAST_NOCK = 4'd14;
   localparam logic [3:0] AT_LAST_CK   = 4'd7;
   localparam logic [3:0] AT_LAST_NOCK = 4'd6;
   localparam logic [3:0] BD_LAST_CK   = 4'd1;
   localparam logic [3:0] BD_LAST_NOCK = 4'd0;

   // Logical byte positions inside a begin job.
   localparam logic [3:0] POS_DELIM  = 4'd0;
   localparam logic [3:0] POS_LEN_HI = 4'd1;
   localparam logic [3:0] POS_LEN_LO = 4'd2;
   localparam logic [3:0] POS_TYPE   = 4'd3;
   localparam logic [3:0] POS_ID     = 4'd4;
   localparam logic [3:0] POS_CMD_HI = 4'd5;
   localparam logic [3:0] POS_CMD_LO = 4'd6;
   localparam logic [3:0] POS_ADR_HI = 4'd11;
   localparam logic [3:0] POS_ADR_LO = 4'd12;

   typedef enum logic [1:0] {
      JOB_TX,
      JOB_AT,
      JOB_BODY
   } job_kind_type;

   // One accepted beat, reduced to the logical bytes it sends.
   typedef struct packed {
      job_kind_type kind;
      logic [8:0]   len_field;
      logic [7:0]   type_byte;
      logic [7:0]   frame_id;
      logic [7:0]   cmd_hi;
      logic [7:0]   cmd_lo;
      logic [7:0]   data;
      logic [7:0]   checksum;
      logic         has_ck;
      logic [3:0]   last_idx;
   } job_type;

   // Emitter status seen by the top level.
   typedef struct packed {
      logic take_ok;
      logic busy;
      logic job_done;
      logic esc_pending;
   } emit_stat_type;

   // Logical (unescaped) byte at a position of a job.
   function automatic logic [7:0] job_byte(input job_type j, input logic [3:0] idx);
      logic [7:0] b;
      b = ZERO_BYTE;
      if (j.has_ck && (idx == j.last_idx)) begin
         b = j.checksum;
      end else if (j.kind == JOB_BODY) begin
         b = j.data;
      end else begin
         unique case (idx)
            POS_DELIM:  b = DELIM;
            POS_LEN_HI: b = {7'd0, j.len_field[8]};
            POS_LEN_LO: b = j.len_field[7:0];
            POS_TYPE:   b = j.type_byte;
            POS_ID:     b = j.frame_id;
            POS_CMD_HI: b = (j.kind == JOB_AT) ? j.cmd_hi : ZERO_BYTE;
            POS_CMD_LO: b = (j.kind == JOB_AT) ? j.cmd_lo : ZERO_BYTE;
            POS_ADR_HI: b = ADDR_HI;
            POS_ADR_LO: b = ADDR_LO;
            default:    b = ZERO_BYTE;
         endcase
      end
      return b;
   endfunction

   // Bytes that must go out as an escape pair.
   function automatic logic needs_escape(input logic [7:0] b);
      return (b == DELIM) || (b == ESC) || (b == XON) || (b == XOFF);
   endfunction

   // Everything but the start delimiter of a frame is subject to escaping.
   function automatic logic escapable(input job_type j, input logic [3:0] idx);
      return !((j.kind != JOB_BODY) && (idx == POS_DELIM));
   endfunction

endpackage

`default_nettype wire

// ----- design/eafe_req_if.sv -----
// Input channel: begin and body beats with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface eafe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  body_length;
   logic [15:0] command_chars;
   logic [7:0]  data_byte;

   modport source (output valid, kind, body_length, command_chars, data_byte,
                   input ready);
   modport sink   (input valid, kind, body_length, command_chars, data_byte,
                   output ready);
endinterface

`default_nettype wire

// ----- design/eafe_rsp_if.sv -----
// Result channel: escaped wire bytes with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface eafe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       end_of_frame;

   modport source (output valid, out_byte, last_of_run, end_of_frame, input ready);
   modport sink   (input valid, out_byte, last_of_run, end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- design/eafe_front.sv -----
// Frame state, configuration registers and job building for each accepted beat.
`timescale 1ns / 1ps
`default_nettype none

module eafe_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire [eafe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [7:0]                          csr_wdata,
   input  wire                                item_fire,
   input  wire [1:0]                          kind,
   input  wire [7:0]                          body_length,
   input  wire [15:0]                         command_chars,
   input  wire [7:0]                          data_byte,
   output eafe_pkg::job_type                  job,
   output logic                               job_valid
);

   logic [7:0] tx_type_ff;
   logic [7:0] at_type_ff;
   logic [7:0] counter_ff, counter_in;
   logic       open_ff, open_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] sum_ff, sum_in;

   logic [7:0] blen;
   logic [7:0] frame_id;
   logic [7:0] hdr_sum;
   logic [7:0] body_sum;
   logic       is_tx;

   // Build the job and the next frame state for the beat on the input.
   always_comb begin
      blen      = (body_length > 8'(eafe_pkg::MAX_BODY)) ?
                  8'(eafe_pkg::MAX_BODY) : body_length;
      frame_id  = counter_ff + 8'd1;
      is_tx     = (kind == eafe_pkg::KIND_BEGIN_TX);
      hdr_sum   = is_tx ?
                  (tx_type_ff + frame_id + eafe_pkg::ADDR_HI + eafe_pkg::ADDR_LO) :
                  (at_type_ff + frame_id + command_chars[15:8] + command_chars[7:0]);
      body_sum  = sum_ff + data_byte;

      counter_in = counter_ff;
      open_in    = open_ff;
      remain_in  = remain_ff;
      sum_in     = sum_ff;
      job        = '0;
      job_valid  = 1'b0;

      case (kind) inside
         eafe_pkg::KIND_BEGIN_TX, eafe_pkg::KIND_BEGIN_AT: begin
            job_valid     = 1'b1;
            job.kind      = is_tx ? eafe_pkg::JOB_TX : eafe_pkg::JOB_AT;
            job.len_field = {1'b0, blen} +
                            (is_tx ? eafe_pkg::TX_HDR_LEN : eafe_pkg::AT_HDR_LEN);
            job.type_byte = is_tx ? tx_type_ff : at_type_ff;
            job.frame_id  = frame_id;
            job.cmd_hi    = command_chars[15:8];
            job.cmd_lo    = command_chars[7:0];
            job.has_ck    = (blen == 8'd0);
            job.checksum  = eafe_pkg::CK_BASE - hdr_sum;
            if (is_tx) begin
               job.last_idx = job.has_ck ? eafe_pkg::TX_LAST_CK : eafe_pkg::TX_LAST_NOCK;
            end else begin
               job.last_idx = job.has_ck ? eafe_pkg::AT_LAST_CK : eafe_pkg::AT_LAST_NOCK;
            end
            counter_in = frame_id;
            // An empty body closes the frame right away.
            if (blen == 8'd0) begin
               open_in   = 1'b0;
               remain_in = 8'd0;
               sum_in    = 8'd0;
            end else begin
               open_in   = 1'b1;
               remain_in = blen;
               sum_in    = hdr_sum;
            end
         end
         eafe_pkg::KIND_BODY: begin
            // A body beat outside an open frame is dropped.
            if (open_ff && (remain_ff != 8'd0)) begin
               job_valid    = 1'b1;
               job.kind     = eafe_pkg::JOB_BODY;
               job.data     = data_byte;
               job.has_ck   = (remain_ff == 8'd1);
               job.checksum = eafe_pkg::CK_BASE - body_sum;
               job.last_idx = job.has_ck ? eafe_pkg::BD_LAST_CK : eafe_pkg::BD_LAST_NOCK;
               remain_in    = remain_ff - 8'd1;
               if (remain_ff == 8'd1) begin
                  open_in = 1'b0;
                  sum_in  = 8'd0;
               end else begin
                  sum_in  = body_sum;
               end
            end
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   // Frame state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 8'd0;
         open_ff    <= 1'b0;
         remain_ff  <= 8'd0;
         sum_ff     <= 8'd0;
      end else if (item_fire) begin
         counter_ff <= counter_in;
         open_ff    <= open_in;
         remain_ff  <= remain_in;
         sum_ff     <= sum_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_type_ff <= eafe_pkg::TX_TYPE_RST;
         at_type_ff <= eafe_pkg::AT_TYPE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            eafe_pkg::REG_TX_TYPE: tx_type_ff <= csr_wdata;
            eafe_pkg::REG_AT_TYPE: at_type_ff <= csr_wdata;
            default:               tx_type_ff <= tx_type_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/eafe_emit.sv -----
// Job register and byte emitter with escaping, feeding the result register.
`timescale 1ns / 1ps
`default_nettype none

module eafe_emit (
   input  wire                      clock,
   input  wire                      reset,
   input  eafe_pkg::job_type        job,
   input  wire                      job_valid,
   input  wire                      item_fire,
   output eafe_pkg::emit_stat_type  stat,
   eafe_rsp_if.source               rsp_bus
);

   eafe_pkg::job_type job_ff;
   logic              busy_ff, busy_in;
   logic [3:0]        idx_ff, idx_in;
   logic              esc_ff, esc_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_eof_ff, out_eof_in;

   logic [7:0] cur_byte;
   logic       need_esc;
   logic       byte_final;
   logic       at_last;
   logic       out_free;
   logic       advance;
   logic       job_done;
   logic       load_job;

   // Pick the next wire byte of the current job.
   always_comb begin
      cur_byte   = eafe_pkg::job_byte(job_ff, idx_ff);
      need_esc   = eafe_pkg::escapable(job_ff, idx_ff) && eafe_pkg::needs_escape(cur_byte);
      byte_final = esc_ff || !need_esc;
      at_last    = (idx_ff == job_ff.last_idx);
      out_free   = !out_valid_ff || rsp_bus.ready;
      advance    = busy_ff && out_free;
      job_done   = advance && byte_final && at_last;
      load_job   = item_fire && job_valid;

      busy_in      = busy_ff;
      idx_in       = idx_ff;
      esc_in       = esc_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_eof_in   = out_eof_ff;

      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = esc_ff ? (cur_byte ^ eafe_pkg::ESC_XOR) :
                        (need_esc ? eafe_pkg::ESC : cur_byte);
         out_last_in  = byte_final && at_last;
         out_eof_in   = byte_final && at_last && job_ff.has_ck;
         esc_in       = !byte_final;
         if (byte_final) begin
            idx_in = idx_ff + 4'd1;
         end
      end

      // A new job replaces the one that finishes in this cycle.
      if (load_job) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
         esc_in  = 1'b0;
      end else if (job_done) begin
         busy_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 4'd0;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load_job) begin
         job_ff <= job;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_eof_ff  <= out_eof_in;
   end

   assign stat.take_ok     = !busy_ff || job_done;
   assign stat.busy        = busy_ff;
   assign stat.job_done    = job_done;
   assign stat.esc_pending = esc_ff;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.out_byte     = out_byte_ff;
   assign rsp_bus.last_of_run  = out_last_ff;
   assign rsp_bus.end_of_frame = out_eof_ff;

endmodule

`default_nettype wire

// ----- design/escaped_api_frame_encoder_core.sv -----
// Top level of the escaped API frame encoder.
`timescale 1ns / 1ps
`default_nettype none

// Turns begin and body beats into the escaped byte stream of API frames, one
// wire byte per cycle while the result channel is ready. A transmit begin
// beat sends 15 to 18 bytes (16 to 19 with the checksum of an empty frame), an
// AT begin beat 7 to 12 (8 to 13 with the checksum), and a body beat 1 to 4;
// an escaped byte goes out as a pair. All frame bytes pass through the single
// byte-wide result register. The next beat is taken in the cycle the current
// run sends its final byte, and beats that send nothing (a body beat with no
// frame open, kind 3) are taken whenever the emitter is free. Configuration
// writes take effect on the following beat; a begin beat while a frame is
// open drops the open frame without its checksum.
module escaped_api_frame_encoder_core (
   input  wire                               clock,
   input  wire                               reset,
   eafe_req_if.sink                          req_bus,
   eafe_rsp_if.source                        rsp_bus,
   input  wire                               csr_we,
   input  wire [eafe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [7:0]                         csr_wdata
);

`include "assert_macros.svh"

   eafe_pkg::job_type       job;
   logic                    job_valid;
   eafe_pkg::emit_stat_type stat;
   logic                    req_fire;

   // A beat is taken whenever the emitter can start a new job.
   assign req_bus.ready = stat.take_ok;
   assign req_fire      = req_bus.valid && stat.take_ok;

   eafe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .item_fire     (req_fire),
      .kind          (req_bus.kind),
      .body_length   (req_bus.body_length),
      .command_chars (req_bus.command_chars),
      .data_byte     (req_bus.data_byte),
      .job           (job),
      .job_valid     (job_valid)
   );

   eafe_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .item_fire (req_fire),
      .stat      (stat),
      .rsp_bus   (rsp_bus)
   );

   // The checksum byte always closes its run.
   `EAFE_ASSERT_IMP(a_eof_is_last, clock, reset, rsp_bus.valid && rsp_bus.end_of_frame, rsp_bus.last_of_run)
   // While the second half of an escape pair waits, the escape byte is on the output.
   `EAFE_ASSERT_IMP(a_esc_shown, clock, reset, stat.esc_pending, rsp_bus.valid && (rsp_bus.out_byte == eafe_pkg::ESC))
   // A finished job with no beat behind it leaves the emitter idle.
   `EAFE_ASSERT_NEXT(a_done_idle, clock, reset, stat.job_done && !req_fire, !stat.busy && !stat.esc_pending)

endmodule

`default_nettype wire
